/* rtl/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame decoder.
`default_nettype none

package wsd_pkg;

    // Default width of the frame payload length
    localparam int LEN_BITS_DEFAULT = 64;

    // Second header byte fields
    localparam logic [7:0] HDR_MASK_BIT = 8'h80;
    localparam logic [7:0] HDR_LEN_MASK = 8'h7F;
    localparam logic [6:0] LEN7_EXT16  = 7'd126;
    localparam logic [6:0] LEN7_EXT64  = 7'd127;

    // Reset value of the keep limit
    localparam logic [31:0] KEEP_LIMIT_RESET = 32'hFFFF_FFFF;

    // One result of the parser for one consumed byte
    typedef struct packed {
        logic        emit;
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        frame_end;
        logic [31:0] kept_length;
    } wsd_result_t;

endpackage : wsd_pkg

`default_nettype wire

/* rtl/websocket_frame_decoder.sv */
// Top level of the WebSocket frame decoder: input register, parser, result register.
`default_nettype none

// Takes one received byte per item and takes WebSocket frames apart: two header
// bytes, an optional 16- or 64-bit big-endian extended length, an optional 4-byte
// mask key, then the payload, unmasked by XOR with the key byte at index mod 4.
// Only the first keep_limit payload bytes of a frame come out; the last result of
// every frame (also of an empty one) carries frame_end and the kept length. Header
// bytes and dropped payload bytes give no result unless they end a frame. The block
// takes one byte every cycle unless the result register stalls; a byte passes
// through the input register, then through the parser into the result register.
// Only a stalled result register slows input. Write keep_limit only
// while the block is idle.
module websocket_frame_decoder
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data_byte,
    output logic             byte_valid,
    output logic             frame_end,
    output logic [31:0]      kept_length
);

    logic [31:0]  keep_limit_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    wsd_result_t  out_reg;
    wsd_result_t  result;
    logic         advance;

    // Move the held item through the parser when the result slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_limit_reg <= KEEP_LIMIT_RESET;
        else if (cfg_wr_en)
            keep_limit_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rx_byte;
    end

    wsd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .step_byte  (in_byte_reg),
        .keep_limit (keep_limit_reg),
        .result     (result)
    );

    // Result register: load a new result, or drop the taken one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= result.emit;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign data_byte   = out_reg.data_byte;
    assign byte_valid  = out_reg.byte_valid;
    assign frame_end   = out_reg.frame_end;
    assign kept_length = out_reg.kept_length;

`ifndef SYNTHESIS
    // A result always carries a byte or a frame end
    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid || frame_end))
        else $error("empty result presented");

    // Kept length is zero except on a frame end
    a_kept_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_end) |-> (kept_length == 32'd0))
        else $error("kept length outside frame end");

    // Dropped bytes carry zero data
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (data_byte == 8'd0))
        else $error("data on a result without a byte");

    // An empty result slot never stalls input
    a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with free result slot");
`endif

endmodule : websocket_frame_decoder

`default_nettype wire

/* rtl/wsd_parser.sv */
// Frame parser: header, extended length, mask key and payload state machine.
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
#(
    parameter int LEN_BITS = LEN_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic [7:0]  step_byte,
    input  wire logic [31:0] keep_limit,
    output wsd_result_t      result
);

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    localparam int CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    localparam logic [3:0] EXT_CNT16 = 4'd2;
    localparam logic [3:0] EXT_CNT64 = 4'd8;
    localparam logic [3:0] KEY_CNT   = 4'd4;

    logic [2:0]          phase_reg, phase_next;
    logic [3:0]          ext_left_reg, ext_left_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic                mask_en_reg, mask_en_next;
    logic [31:0]         key_reg, key_next;
    logic [LEN_BITS-1:0] idx_reg, idx_next;
    logic [31:0]         kept_reg, kept_next;

    logic [6:0]          len7;
    logic [LEN_BITS-1:0] len_shift;
    logic [LEN_BITS-1:0] idx_inc;
    logic                deliver;
    logic                last;
    logic [7:0]          key_byte;
    logic [7:0]          plain;
    logic [31:0]         kept_inc;

    // Payload byte datapath
    always_comb
    begin
        idx_inc  = idx_reg + LEN_BITS'(1);
        deliver  = CMP_W'(idx_reg) < CMP_W'(keep_limit);
        last     = (idx_inc == len_reg);
        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        plain    = mask_en_reg ? (step_byte ^ key_byte) : step_byte;
        kept_inc = kept_reg + 32'd1;
        len7     = step_byte[6:0] & HDR_LEN_MASK[6:0];
        // Saturate a length that would overflow the length register
        if (len_reg[LEN_BITS-1 -: 8] != 8'd0)
            len_shift = LEN_MAX;
        else
            len_shift = {len_reg[LEN_BITS-9:0], step_byte};
    end

    // Next state and result for the consumed byte
    always_comb
    begin
        phase_next    = phase_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        mask_en_next  = mask_en_reg;
        key_next      = key_reg;
        idx_next      = idx_reg;
        kept_next     = kept_reg;
        result        = '0;

        case (phase_reg)
            PH_HDR1:
            begin
                mask_en_next = (step_byte & HDR_MASK_BIT) != 8'd0;
                len_next     = '0;
                if (len7 == LEN7_EXT16)
                begin
                    ext_left_next = EXT_CNT16;
                    phase_next    = PH_EXT;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    ext_left_next = EXT_CNT64;
                    phase_next    = PH_EXT;
                end
                else
                begin
                    len_next  = LEN_BITS'(len7);
                    idx_next  = '0;
                    kept_next = '0;
                    if (mask_en_next)
                    begin
                        ext_left_next = KEY_CNT;
                        phase_next    = PH_KEY;
                    end
                    else if (len7 == 7'd0)
                    begin
                        result.emit      = 1'b1;
                        result.frame_end = 1'b1;
                        phase_next       = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end

            PH_EXT:
            begin
                len_next      = len_shift;
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_next == 4'd0)
                begin
                    idx_next  = '0;
                    kept_next = '0;
                    if (mask_en_reg)
                    begin
                        ext_left_next = KEY_CNT;
                        phase_next    = PH_KEY;
                    end
                    else if (len_shift == '0)
                    begin
                        result.emit      = 1'b1;
                        result.frame_end = 1'b1;
                        phase_next       = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end

            PH_KEY:
            begin
                key_next      = {key_reg[23:0], step_byte};
                ext_left_next = ext_left_reg - 4'd1;
                if (ext_left_next == 4'd0)
                begin
                    if (len_reg == '0)
                    begin
                        result.emit      = 1'b1;
                        result.frame_end = 1'b1;
                        phase_next       = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end

            PH_DATA:
            begin
                idx_next = idx_inc;
                if (deliver)
                    kept_next = kept_inc;
                if (last)
                    phase_next = PH_HDR0;
                result.emit        = deliver || last;
                result.byte_valid  = deliver;
                result.data_byte   = deliver ? plain : 8'd0;
                result.frame_end   = last;
                result.kept_length = last ? kept_next : 32'd0;
            end

            default:
            begin
                phase_next = PH_HDR1;
            end
        endcase

        // Emit no result when no byte is consumed; the state registers hold
        if (!step_en)
            result.emit = 1'b0;
    end

    // Advance the parser state on a consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR0;
            ext_left_reg <= '0;
            len_reg      <= '0;
            mask_en_reg  <= 1'b0;
            key_reg      <= '0;
            idx_reg      <= '0;
            kept_reg     <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            ext_left_reg <= ext_left_next;
            len_reg      <= len_next;
            mask_en_reg  <= mask_en_next;
            key_reg      <= key_next;
            idx_reg      <= idx_next;
            kept_reg     <= kept_next;
        end
    end

endmodule : wsd_parser

`default_nettype wire
